/* hw/rtl/assert_macros.svh */
// Assertion helpers for the checker in mlk_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, masked during reset
`define MLK_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, masked during reset
`define MLK_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// next-cycle implication that also holds across reset
`define MLK_ASSERT_NXT_ANY(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/mlk_pkg.sv */
`timescale 1ns / 1ps

package mlk_pkg;

  localparam int unsigned TickW = 16;
  localparam int unsigned CfgW  = 16;

  localparam logic [TickW-1:0] DotReset  = 16'd100;
  localparam logic [TickW-1:0] DashReset = 16'd200;
  localparam logic [TickW-1:0] GapReset  = 16'd100;

  localparam logic [7:0] CharLo = 8'h61;
  localparam logic [7:0] CharHi = 8'h7A;

  typedef enum logic [1:0] {
    REG_DOT  = 2'd0,
    REG_DASH = 2'd1,
    REG_GAP  = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_MARK = 2'd1,
    PH_GAP  = 2'd2,
    PH_END  = 2'd3
  } phase_t;

  typedef enum logic {
    MODE_CHAR = 1'b0,
    MODE_TICK = 1'b1
  } mode_t;

  typedef struct packed {
    logic [TickW-1:0] dot_ticks;
    logic [TickW-1:0] dash_ticks;
    logic [TickW-1:0] gap_ticks;
  } cfg_t;

  typedef struct packed {
    logic light_on;
    logic busy_res;
    logic accepted;
    logic bad_char;
  } res_t;

  // zero in a timing register counts as a single tick
  function automatic logic [TickW-1:0] at_least_one(input logic [TickW-1:0] v);
    at_least_one = (v == '0) ? {{(TickW-1){1'b0}}, 1'b1} : v;
  endfunction

  // element count in [6:4], elements in [3:0], first in bit 0, 1 = dash
  function automatic logic [6:0] letter_code(input logic [4:0] idx);
    case (idx)
      5'd0:    letter_code = 7'h22;
      5'd1:    letter_code = 7'h41;
      5'd2:    letter_code = 7'h45;
      5'd3:    letter_code = 7'h31;
      5'd4:    letter_code = 7'h10;
      5'd5:    letter_code = 7'h44;
      5'd6:    letter_code = 7'h33;
      5'd7:    letter_code = 7'h40;
      5'd8:    letter_code = 7'h20;
      5'd9:    letter_code = 7'h4E;
      5'd10:   letter_code = 7'h35;
      5'd11:   letter_code = 7'h42;
      5'd12:   letter_code = 7'h23;
      5'd13:   letter_code = 7'h21;
      5'd14:   letter_code = 7'h37;
      5'd15:   letter_code = 7'h46;
      5'd16:   letter_code = 7'h4B;
      5'd17:   letter_code = 7'h32;
      5'd18:   letter_code = 7'h30;
      5'd19:   letter_code = 7'h11;
      5'd20:   letter_code = 7'h34;
      5'd21:   letter_code = 7'h48;
      5'd22:   letter_code = 7'h36;
      5'd23:   letter_code = 7'h49;
      5'd24:   letter_code = 7'h4D;
      5'd25:   letter_code = 7'h43;
      default: letter_code = 7'h00;
    endcase
  endfunction

endpackage

/* hw/rtl/morse_letter_keyer_top.sv */
`timescale 1ns / 1ps

// Morse letter keyer.
// Input channel (in_valid/in_ready): mode 0 offers a character in char_code,
// mode 1 marks one time tick. Every input transaction yields exactly one
// result transaction (out_valid/out_ready) carrying light_on, busy_res,
// accepted and bad_char as they stand after that item.
// A character is only taken while nothing is being sent; otherwise the
// result reports accepted 0 and the keyer carries on.
// Path: each item passes the input register, then the result register, whose
// contents form the result transaction.
// Throughput: one item per cycle unless the receiver stalls, set by the single
// table lookup and tick counter update between those two registers.
// Receiver stall: the result register holds; the input register still takes
// one more item, after which in_ready drops until the result is taken.
// Timing registers are written through cfg_we/cfg_index/cfg_wdata
// (0 dot, 1 dash, 2 gap); a value of 0 behaves as 1 tick.
// Reset (rst, synchronous): registers back to 100/200/100, keyer idle,
// both pipeline registers empty.
module morse_letter_keyer_top (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     mode,
  input  logic [7:0]               char_code,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     light_on,
  output logic                     busy_res,
  output logic                     accepted,
  output logic                     bad_char,
  input  logic                     cfg_we,
  input  logic [1:0]               cfg_index,
  input  logic [mlk_pkg::CfgW-1:0] cfg_wdata
);
  import mlk_pkg::*;

  cfg_t       cfg;
  res_t       res;
  logic       in_vld;
  logic       in_mode;
  logic [7:0] in_char;
  logic       advance;

  // result slot frees up this cycle
  assign advance  = !out_valid || out_ready;
  assign in_ready = !in_vld || advance;

  mlk_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  mlk_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .step      (in_vld && advance),
    .mode      (in_mode),
    .char_code (in_char),
    .cfg       (cfg),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (in_ready) begin
      in_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_mode <= mode;
      in_char <= char_code;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (in_vld && advance) begin
      light_on <= res.light_on;
      busy_res <= res.busy_res;
      accepted <= res.accepted;
      bad_char <= res.bad_char;
    end
  end

endmodule

/* hw/rtl/mlk_cfg_regs.sv */
`timescale 1ns / 1ps

module mlk_cfg_regs (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_index,
  input  logic [mlk_pkg::CfgW-1:0]  cfg_wdata,
  output mlk_pkg::cfg_t             cfg
);
  import mlk_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dot_ticks  <= DotReset;
      cfg.dash_ticks <= DashReset;
      cfg.gap_ticks  <= GapReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DOT:  cfg.dot_ticks  <= cfg_wdata;
        REG_DASH: cfg.dash_ticks <= cfg_wdata;
        REG_GAP:  cfg.gap_ticks  <= cfg_wdata;
        default:  ;
      endcase
    end
  end

endmodule

/* hw/rtl/mlk_engine.sv */
`timescale 1ns / 1ps

module mlk_engine (
  input  logic           clk,
  input  logic           rst,
  input  logic           step,
  input  logic           mode,
  input  logic [7:0]     char_code,
  input  mlk_pkg::cfg_t  cfg,
  output mlk_pkg::res_t  res
);
  import mlk_pkg::*;

  phase_t           phase, phase_next;
  logic [3:0]       pattern_bits, pattern_bits_next;
  logic [2:0]       elements_left, elements_left_next;
  logic [TickW-1:0] tick_count, tick_count_next;
  logic             took, bad;

  logic [TickW-1:0] cnt_dec;
  logic [7:0]       char_off;
  logic [6:0]       code;
  logic             is_letter;
  logic [TickW-1:0] dot_len, dash_len, gap_len;

  assign cnt_dec   = (tick_count != '0) ? tick_count - 16'd1 : '0;
  assign char_off  = char_code - CharLo;
  assign code      = letter_code(char_off[4:0]);
  assign is_letter = (char_code >= CharLo) && (char_code <= CharHi);
  assign dot_len   = at_least_one(cfg.dot_ticks);
  assign dash_len  = at_least_one(cfg.dash_ticks);
  assign gap_len   = at_least_one(cfg.gap_ticks);

  always_comb begin
    phase_next         = phase;
    pattern_bits_next  = pattern_bits;
    elements_left_next = elements_left;
    tick_count_next    = tick_count;
    took               = 1'b0;
    bad                = 1'b0;
    if (step) begin
      if (mode == MODE_TICK) begin
        if (phase != PH_IDLE) begin
          if (cnt_dec != '0) begin
            tick_count_next = cnt_dec;
          end else begin
            unique case (phase)
              PH_MARK: begin
                phase_next      = PH_GAP;
                tick_count_next = gap_len;
              end
              PH_GAP: begin
                if (elements_left != '0) begin
                  elements_left_next = elements_left - 3'd1;
                  pattern_bits_next  = {1'b0, pattern_bits[3:1]};
                  phase_next         = PH_MARK;
                  tick_count_next    = pattern_bits[0] ? dash_len : dot_len;
                end else begin
                  phase_next      = PH_END;
                  tick_count_next = gap_len;
                end
              end
              PH_END: begin
                phase_next         = PH_IDLE;
                pattern_bits_next  = '0;
                elements_left_next = '0;
                tick_count_next    = cnt_dec;
              end
              default: ;
            endcase
          end
        end
      end else if (phase == PH_IDLE) begin
        took = 1'b1;
        if (is_letter) begin
          pattern_bits_next  = {1'b0, code[3:1]};
          elements_left_next = code[6:4] - 3'd1;
          phase_next         = PH_MARK;
          tick_count_next    = code[0] ? dash_len : dot_len;
        end else begin
          bad                = 1'b1;
          pattern_bits_next  = '0;
          elements_left_next = '0;
          phase_next         = PH_END;
          tick_count_next    = gap_len;
        end
      end
    end
  end

  always_comb begin
    res.light_on = (phase_next == PH_MARK);
    res.busy_res = (phase_next != PH_IDLE);
    res.accepted = took;
    res.bad_char = bad;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      pattern_bits  <= '0;
      elements_left <= '0;
      tick_count    <= '0;
    end else begin
      phase         <= phase_next;
      pattern_bits  <= pattern_bits_next;
      elements_left <= elements_left_next;
      tick_count    <= tick_count_next;
    end
  end

endmodule

/* hw/rtl/mlk_checker.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mlk_checker (
  input logic clk,
  input logic rst,
  input logic out_valid,
  input logic out_ready,
  input logic light_on,
  input logic busy_res,
  input logic accepted,
  input logic bad_char
);

  `MLK_ASSERT_NXT_ANY(a_reset_empty, clk, rst, !out_valid, "result valid straight after reset")

  `MLK_ASSERT_IMP(a_light_busy, clk, rst, out_valid && light_on, busy_res, "light on while idle")

  `MLK_ASSERT_IMP(a_bad_taken, clk, rst, out_valid && bad_char, accepted && busy_res && !light_on, "bad character flag without taken character and closing gap")

  `MLK_ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(light_on) && $stable(busy_res) && $stable(accepted) && $stable(bad_char), "stalled result transaction changed")

endmodule

bind morse_letter_keyer_top mlk_checker u_mlk_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .light_on  (light_on),
  .busy_res  (busy_res),
  .accepted  (accepted),
  .bad_char  (bad_char)
);

/* verif/morse_keyer_checker.sv */
`timescale 1ns / 1ps

module morse_keyer_checker
  import mlk_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            in_ready,
  input  logic            mode,
  input  logic [7:0]      char_code,
  input  logic            out_valid,
  input  logic            out_ready,
  input  logic            light_on,
  input  logic            busy_res,
  input  logic            accepted,
  input  logic            bad_char,
  input  logic            cfg_we,
  input  logic [1:0]      cfg_index,
  input  logic [CfgW-1:0] cfg_wdata,
  output int              fail_count,
  output int              pending,
  output logic            keyer_busy,
  output int              results_seen,
  output int              letters_keyed,
  output int              bad_keyed,
  output int              refused
);

  cfg_t             timing;
  phase_t           key_phase;
  logic [3:0]       elem_bits;    // elements still to send, next in bit 0, 1 = dash
  logic [2:0]       elems_to_go;
  logic [TickW-1:0] ticks_left;
  res_t             expected_levels[$];

  function automatic logic [TickW-1:0] ticks_min1(input logic [TickW-1:0] v);
    return (v == '0) ? TickW'(1) : v;
  endfunction

  // {element count, elements}, first element in bit 0, 1 = dash
  function automatic logic [6:0] morse_shape(input logic [7:0] ch);
    logic [6:0] shape;
    case (ch)
      "a": shape = {3'd2, 4'b0010};
      "b": shape = {3'd4, 4'b0001};
      "c": shape = {3'd4, 4'b0101};
      "d": shape = {3'd3, 4'b0001};
      "e": shape = {3'd1, 4'b0000};
      "f": shape = {3'd4, 4'b0100};
      "g": shape = {3'd3, 4'b0011};
      "h": shape = {3'd4, 4'b0000};
      "i": shape = {3'd2, 4'b0000};
      "j": shape = {3'd4, 4'b1110};
      "k": shape = {3'd3, 4'b0101};
      "l": shape = {3'd4, 4'b0010};
      "m": shape = {3'd2, 4'b0011};
      "n": shape = {3'd2, 4'b0001};
      "o": shape = {3'd3, 4'b0111};
      "p": shape = {3'd4, 4'b0110};
      "q": shape = {3'd4, 4'b1011};
      "r": shape = {3'd3, 4'b0010};
      "s": shape = {3'd3, 4'b0000};
      "t": shape = {3'd1, 4'b0001};
      "u": shape = {3'd3, 4'b0100};
      "v": shape = {3'd4, 4'b1000};
      "w": shape = {3'd3, 4'b0110};
      "x": shape = {3'd4, 4'b1001};
      "y": shape = {3'd4, 4'b1101};
      "z": shape = {3'd4, 4'b0011};
      default: shape = '0;
    endcase
    return shape;
  endfunction

  task automatic begin_element();
    key_phase  = PH_MARK;
    ticks_left = ticks_min1(elem_bits[0] ? timing.dash_ticks : timing.dot_ticks);
    elem_bits  = elem_bits >> 1;
  endtask

  // advance the keyer by one input item and give the levels it leaves
  task automatic key_item(input logic m, input logic [7:0] ch, output res_t r);
    logic [6:0] shape;
    r = '0;
    if (m == MODE_TICK) begin
      if (key_phase != PH_IDLE) begin
        if (ticks_left != '0) ticks_left = ticks_left - 1'b1;
        if (ticks_left == '0) begin
          case (key_phase)
            PH_MARK: begin
              key_phase  = PH_GAP;
              ticks_left = ticks_min1(timing.gap_ticks);
            end
            PH_GAP: begin
              if (elems_to_go != '0) begin
                elems_to_go = elems_to_go - 1'b1;
                begin_element();
              end else begin
                key_phase  = PH_END;
                ticks_left = ticks_min1(timing.gap_ticks);
              end
            end
            default: begin
              key_phase   = PH_IDLE;
              elem_bits   = '0;
              elems_to_go = '0;
            end
          endcase
        end
      end
    end else if (key_phase == PH_IDLE) begin
      r.accepted = 1'b1;
      if (ch >= CharLo && ch <= CharHi) begin
        shape       = morse_shape(ch);
        elem_bits   = shape[3:0];
        elems_to_go = shape[6:4] - 1'b1;
        begin_element();
      end else begin
        // not a letter: no mark, only the closing gap
        r.bad_char  = 1'b1;
        elem_bits   = '0;
        elems_to_go = '0;
        key_phase   = PH_END;
        ticks_left  = ticks_min1(timing.gap_ticks);
      end
    end
    r.light_on = (key_phase == PH_MARK);
    r.busy_res = (key_phase != PH_IDLE);
  endtask

  task automatic check_field(input string name, input logic want, input logic got);
    if (want !== got) begin
      fail_count++;
      $display("%0t ns: %s expected %0b, got %0b", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    res_t want;
    if (rst) begin
      timing.dot_ticks  = DotReset;
      timing.dash_ticks = DashReset;
      timing.gap_ticks  = GapReset;
      key_phase     = PH_IDLE;
      elem_bits     = '0;
      elems_to_go   = '0;
      ticks_left    = '0;
      expected_levels.delete();
      fail_count    = 0;
      results_seen  = 0;
      letters_keyed = 0;
      bad_keyed     = 0;
      refused       = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_DOT:  timing.dot_ticks  = cfg_wdata;
          REG_DASH: timing.dash_ticks = cfg_wdata;
          REG_GAP:  timing.gap_ticks  = cfg_wdata;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_levels.size() == 0) begin
          fail_count++;
          $display("%0t ns: result transaction with none expected, got %b%b%b%b",
                   $time, light_on, busy_res, accepted, bad_char);
        end else begin
          want = expected_levels.pop_front();
          check_field("light_on", want.light_on, light_on);
          check_field("busy_res", want.busy_res, busy_res);
          check_field("accepted", want.accepted, accepted);
          check_field("bad_char", want.bad_char, bad_char);
        end
      end
      if (in_valid && in_ready) begin
        key_item(mode, char_code, want);
        if (want.accepted) begin
          if (want.bad_char) bad_keyed++;
          else letters_keyed++;
        end else if (mode == MODE_CHAR) begin
          refused++;
        end
        expected_levels.push_back(want);
      end
    end
    pending    <= expected_levels.size();
    keyer_busy <= (key_phase != PH_IDLE);
  end

endmodule

/* verif/morse_letter_keyer_top_tb.sv */
`timescale 1ns / 1ps

module morse_letter_keyer_top_tb;
  import mlk_pkg::*;

  localparam int         Latency    = 2;
  localparam int         QuietLimit = 4000;
  localparam int         HoldCycles = 300;
  localparam int         PhaseItems = 55;
  localparam logic [1:0] RegSpare   = 2'd3;  // no register here, write is dropped

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  logic            clk;
  logic            rst;
  logic            in_valid;
  logic            in_ready;
  logic            mode;
  logic [7:0]      char_code;
  logic            out_valid;
  logic            out_ready;
  logic            light_on;
  logic            busy_res;
  logic            accepted;
  logic            bad_char;
  logic            cfg_we;
  logic [1:0]      cfg_index;
  logic [CfgW-1:0] cfg_wdata;

  int         fail_count;
  int         pending;
  logic       keyer_busy;
  int         results_seen;
  int         letters_keyed;
  int         bad_keyed;
  int         refused;
  idle_mode_t idle_mode;
  bit         hold_req;

  morse_letter_keyer_top dut (.*);
  morse_keyer_checker chk (.*);

  initial begin : clock_gen
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit stall_now(input bit sender);
    int pct;
    pct = (idle_mode == IDLE_BOTH) ? 21 : 73;
    if (idle_mode == IDLE_NONE) return 1'b0;
    if (sender && idle_mode == IDLE_RECV) return 1'b0;
    if (!sender && idle_mode == IDLE_SEND) return 1'b0;
    return $urandom_range(99) < pct;
  endfunction

  initial begin : receiver
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        // long hold-off so the pipeline fills and in_ready drops
        out_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_ready <= !stall_now(1'b0);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    wait (rst === 1'b0);
    while (quiet < QuietLimit) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("watchdog: no transaction for %0d cycles", QuietLimit);
    $display("morse_letter_keyer_top: mismatch");
    $finish;
  end

  task automatic send_item(input mode_t m, input logic [7:0] ch);
    while (stall_now(1'b1)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    mode      <= m;
    char_code <= ch;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // keyer_busy lags one transaction, so this may send one spare tick while idle
  task automatic drain_keyer();
    do send_item(MODE_TICK, 8'($urandom_range(255))); while (keyer_busy);
  endtask

  task automatic key_letter(input logic [7:0] ch);
    send_item(MODE_CHAR, ch);
    drain_keyer();
  endtask

  task automatic quiesce();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (Latency + 2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [CfgW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic set_timing(input logic [CfgW-1:0] dot, input logic [CfgW-1:0] dash,
                            input logic [CfgW-1:0] gap);
    write_reg(REG_DOT, dot);
    write_reg(REG_DASH, dash);
    write_reg(REG_GAP, gap);
    write_reg(RegSpare, CfgW'($urandom_range(65535)));
    cfg_we <= 1'b0;
  endtask

  task automatic send_random_item();
    int         pick;
    logic [7:0] ch;
    pick = $urandom_range(99);
    if (pick < 70) begin
      send_item(MODE_TICK, 8'($urandom_range(255)));
    end else begin
      if (pick < 86) begin
        ch = CharLo + 8'($urandom_range(25));
      end else if (pick < 94) begin
        ch = 8'($urandom_range(255));
      end else begin
        case ($urandom_range(3))
          0: ch = CharLo - 8'd1;
          1: ch = CharHi + 8'd1;
          2: ch = '0;
          default: ch = '1;
        endcase
      end
      send_item(MODE_CHAR, ch);
    end
  endtask

  task automatic random_phase(input idle_mode_t im, input bit squeeze);
    set_timing(CfgW'($urandom_range(6)), CfgW'($urandom_range(9)),
               CfgW'($urandom_range(5)));
    idle_mode = im;
    if (squeeze) hold_req = 1'b1;
    repeat (PhaseItems) send_random_item();
    drain_keyer();
    quiesce();
  endtask

  initial begin : stimulus
    string word;
    rst       = 1'b1;
    in_valid  = 1'b0;
    mode      = MODE_TICK;
    char_code = '0;
    cfg_we    = 1'b0;
    cfg_index = REG_DOT;
    cfg_wdata = '0;
    idle_mode = IDLE_NONE;
    hold_req  = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset timings: tick while idle, a letter, a character refused mid-letter
    send_item(MODE_TICK, '1);
    send_item(MODE_CHAR, "e");
    repeat (20) send_item(MODE_TICK, 8'($urandom_range(255)));
    send_item(MODE_CHAR, "k");
    drain_keyer();
    quiesce();

    set_timing(16'd1, 16'd2, 16'd1);
    word = "aqzjtm";
    foreach (word[i]) key_letter(word[i]);
    key_letter(CharLo - 8'd1);
    key_letter(CharHi + 8'd1);
    key_letter('0);
    key_letter('1);
    send_item(MODE_CHAR, "b");
    send_item(MODE_CHAR, "c");
    drain_keyer();
    quiesce();

    // zero in every timing register counts as one tick
    set_timing('0, '0, '0);
    key_letter("q");
    key_letter('1);
    quiesce();

    for (int p = 0; p < 8; p++) random_phase(idle_mode_t'(p % 4), p == 4);

    // widest dash and gap: the letter is still being sent when the run ends
    idle_mode = IDLE_NONE;
    set_timing(16'd1, '1, '1);
    send_item(MODE_CHAR, "a");
    repeat (8) send_item(MODE_TICK, 8'($urandom_range(255)));
    send_item(MODE_CHAR, "b");
    quiesce();

    $display("%0d result transactions checked: %0d letters, %0d invalid characters, %0d refused",
             results_seen, letters_keyed, bad_keyed, refused);
    $display("timings from 0 to 65535 ticks, four idling patterns, one long receiver hold-off");
    if (fail_count == 0 && pending == 0) begin
      $display("morse_letter_keyer_top: match");
    end else begin
      $display("morse_letter_keyer_top: mismatch");
    end
    $finish;
  end

endmodule
